FILE: sv/visible_pixel_bounding_box_core_assert.svh
// Assertion macros used by the bounding-box core RTL.
// Each macro is empty in synthesis builds.
`ifndef VISIBLE_PIXEL_BOUNDING_BOX_CORE_ASSERT_SVH
`define VISIBLE_PIXEL_BOUNDING_BOX_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is asserted.
`define VPBB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define VPBB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VPBB_ASSERT(label, clk, rst_n, prop, msg)

`define VPBB_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: sv/vpbb_pkg.sv
package vpbb_pkg;

    // Frame geometry limits.
    localparam int MAX_DIM  = 4096;
    localparam int DIM_W    = 13;
    localparam int COORD_W  = 12;

    // Pixel layout and visibility test.
    localparam int          PIXEL_W         = 32;
    localparam int          ALPHA_LSB       = 24;
    localparam logic [7:0]  ALPHA_MASK      = 8'hFF;
    localparam logic [7:0]  ALPHA_THRESHOLD = 8'd8;
    localparam logic [31:0] RGB_MASK        = 32'h00FF_FFFF;

    // Configuration register map.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_ALPHA_MODE   = 2'd2
    } cfg_reg_t;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
    localparam logic             ALPHA_MODE_RESET   = 1'b1;

    // Position and visibility of the item held in the input register.
    typedef struct packed {
        logic               visible;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               frame_end;
    } scan_t;

    // One finished bounding box.
    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } box_t;

    // A size of zero acts as one and a size above the maximum is clamped.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: sv/vpbb_if.sv
// Pixel stream channel.
interface vpbb_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_argb;

    modport source (output valid, output pixel_argb, input ready);
    modport sink   (input valid, input pixel_argb, output ready);
endinterface

// Bounding-box result channel.
interface vpbb_box_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [11:0] box_left;
    logic [11:0] box_top;
    logic [12:0] box_width;
    logic [12:0] box_height;

    modport source (output valid, output found, output box_left, output box_top,
                    output box_width, output box_height, input ready);
    modport sink   (input valid, input found, input box_left, input box_top,
                    input box_width, input box_height, output ready);
endinterface

FILE: sv/vpbb_scan.sv
module vpbb_scan
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [vpbb_pkg::PIXEL_W-1:0]  pixel,
    input  logic [vpbb_pkg::DIM_W-1:0]    frame_width,
    input  logic [vpbb_pkg::DIM_W-1:0]    frame_height,
    input  logic                          alpha_mode,
    output vpbb_pkg::scan_t               scan
);
    import vpbb_pkg::*;

    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [7:0]         alpha;
    logic               last_col;
    logic               last_row;

    // Visibility test on the held pixel.
    assign alpha = 8'(pixel >> ALPHA_LSB) & ALPHA_MASK;

    assign scan.visible = alpha_mode ? (alpha > ALPHA_THRESHOLD)
                                     : ((pixel & RGB_MASK) != '0);

    // A counter at or past the last column or row counts as being on it.
    assign w_eff    = eff_dim(frame_width);
    assign h_eff    = eff_dim(frame_height);
    assign last_col = ({1'b0, col_reg} + DIM_W'(1)) >= w_eff;
    assign last_row = ({1'b0, row_reg} + DIM_W'(1)) >= h_eff;

    assign scan.col       = col_reg;
    assign scan.row       = row_reg;
    assign scan.frame_end = last_col && last_row;

    // Raster position for the next pixel.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (scan.frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = row_reg + COORD_W'(1);
            end
            else
            begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: sv/vpbb_track.sv
module vpbb_track
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  vpbb_pkg::scan_t scan,
    output vpbb_pkg::box_t  box
);
    import vpbb_pkg::*;

    logic               any_reg, any_next;
    logic [COORD_W-1:0] lcol_reg, lcol_next;
    logic [COORD_W-1:0] gcol_reg, gcol_next;
    logic [COORD_W-1:0] lrow_reg, lrow_next;
    logic [COORD_W-1:0] grow_reg, grow_next;
    logic               upd_any;
    logic [COORD_W-1:0] upd_lcol, upd_gcol, upd_lrow, upd_grow;

    // Bounds including the current pixel.
    always_comb
    begin
        upd_any  = any_reg;
        upd_lcol = lcol_reg;
        upd_gcol = gcol_reg;
        upd_lrow = lrow_reg;
        upd_grow = grow_reg;
        if (scan.visible)
        begin
            upd_any = 1'b1;
            if (!any_reg)
            begin
                upd_lcol = scan.col;
                upd_gcol = scan.col;
                upd_lrow = scan.row;
                upd_grow = scan.row;
            end
            else
            begin
                if (scan.col < lcol_reg)
                    upd_lcol = scan.col;
                if (scan.col > gcol_reg)
                    upd_gcol = scan.col;
                if (scan.row < lrow_reg)
                    upd_lrow = scan.row;
                if (scan.row > grow_reg)
                    upd_grow = scan.row;
            end
        end
    end

    // Box for a frame that ends on the current pixel; all zero when empty.
    always_comb
    begin
        box.found  = upd_any;
        box.left   = '0;
        box.top    = '0;
        box.width  = '0;
        box.height = '0;
        if (upd_any)
        begin
            box.left   = upd_lcol;
            box.top    = upd_lrow;
            box.width  = {1'b0, upd_gcol} - {1'b0, upd_lcol} + DIM_W'(1);
            box.height = {1'b0, upd_grow} - {1'b0, upd_lrow} + DIM_W'(1);
        end
    end

    // Commit the bounds, or clear them at the end of a frame.
    always_comb
    begin
        any_next  = any_reg;
        lcol_next = lcol_reg;
        gcol_next = gcol_reg;
        lrow_next = lrow_reg;
        grow_next = grow_reg;
        if (advance)
        begin
            if (scan.frame_end)
            begin
                any_next  = 1'b0;
                lcol_next = '0;
                gcol_next = '0;
                lrow_next = '0;
                grow_next = '0;
            end
            else
            begin
                any_next  = upd_any;
                lcol_next = upd_lcol;
                gcol_next = upd_gcol;
                lrow_next = upd_lrow;
                grow_next = upd_grow;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg  <= 1'b0;
            lcol_reg <= '0;
            gcol_reg <= '0;
            lrow_reg <= '0;
            grow_reg <= '0;
        end
        else
        begin
            any_reg  <= any_next;
            lcol_reg <= lcol_next;
            gcol_reg <= gcol_next;
            lrow_reg <= lrow_next;
            grow_reg <= grow_next;
        end
    end

endmodule

FILE: sv/visible_pixel_bounding_box_core.sv
// A frame's last pixel is held in the input register, and its box then goes to the result register.
// Throughput: one pixel per cycle, set by the single input register stage; the input
// stalls only when a frame's last pixel finds the result register still occupied.
// Reset clears the raster counters, the bounds and both valid flags, and loads the
// frame size 640 x 480 with alpha mode on.
module visible_pixel_bounding_box_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vpbb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vpbb_pkg::CFG_DATA_W-1:0]   cfg_data,
    vpbb_pixel_if.sink                        pix,
    vpbb_box_if.source                        box
);
    import vpbb_pkg::*;

    `include "visible_pixel_bounding_box_core_assert.svh"

    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic               alpha_mode_reg;
    logic               in_valid_reg, in_valid_next;
    logic [PIXEL_W-1:0] in_pixel_reg;
    logic               out_valid_reg, out_valid_next;
    box_t               out_box_reg;
    logic               advance;
    logic               out_load;
    logic               accept;
    scan_t              scan;
    box_t               frame_box;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            alpha_mode_reg   <= ALPHA_MODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_ALPHA_MODE:   alpha_mode_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // The held item moves on unless it ends a frame while the result is blocked.
    assign advance   = in_valid_reg && (!scan.frame_end || !out_valid_reg || box.ready);
    assign out_load  = advance && scan.frame_end;
    assign pix.ready = !in_valid_reg || advance;
    assign accept    = pix.valid && pix.ready;

    // Input register.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_pixel_reg <= pix.pixel_argb;
    end

    // Raster position and visibility.
    vpbb_scan u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .pixel        (in_pixel_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .alpha_mode   (alpha_mode_reg),
        .scan         (scan)
    );

    // Bounds of the visible pixels.
    vpbb_track u_track
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .scan    (scan),
        .box     (frame_box)
    );

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (box.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_box_reg <= frame_box;
    end

    assign box.valid      = out_valid_reg;
    assign box.found      = out_box_reg.found;
    assign box.box_left   = out_box_reg.left;
    assign box.box_top    = out_box_reg.top;
    assign box.box_width  = out_box_reg.width;
    assign box.box_height = out_box_reg.height;

    // An empty frame reports an all-zero box.
    `VPBB_ASSERT(a_empty_zero, clk, rst_n, (out_valid_reg && !out_box_reg.found) |-> (out_box_reg.left == '0 && out_box_reg.top == '0 && out_box_reg.width == '0 && out_box_reg.height == '0), "empty frame with nonzero box")

    // A found box always covers at least one pixel.
    `VPBB_ASSERT(a_found_size, clk, rst_n, (out_valid_reg && out_box_reg.found) |-> (out_box_reg.width != '0 && out_box_reg.height != '0), "found box with zero size")

    // A result appears only after the last pixel of a frame moved on.
    `VPBB_ASSERT(a_result_source, clk, rst_n, $rose(out_valid_reg) |-> $past(advance && scan.frame_end), "result without frame end")

    // A held item that cannot move on stays held.
    `VPBB_ASSERT(a_hold_item, clk, rst_n, (in_valid_reg && !advance) |=> in_valid_reg, "held item dropped")

    // Reset leaves both stages empty.
    `VPBB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> (!in_valid_reg && !out_valid_reg), "stage valid during reset")

endmodule
